// ===== hw/rtl/bstk_pkg.sv =====
package bstk_pkg;

  // Default sizes
  localparam int unsigned MaxPlatesDef = 128;
  localparam int unsigned StacksDef    = 16;

  // Fixed field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned WordW  = 32;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CapW   = 8;
  localparam int unsigned StatW  = 2;

  localparam logic [CapW-1:0] CapReset = 8'd128;

  typedef enum logic [OpW-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_POP_AT = 2'd2
  } bstk_op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } bstk_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_PLATE,
    S_DONE
  } bstk_state_e;

endpackage

// ===== hw/rtl/bstk_if.sv =====
// Request channel
interface bstk_in_if import bstk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          operation;
  logic signed [WordW-1:0] push_value;
  logic [IdxW-1:0]         stack_index;

  modport source (output valid, operation, push_value, stack_index, input ready);
  modport sink   (input valid, operation, push_value, stack_index, output ready);
endinterface

// Result channel
interface bstk_out_if import bstk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] popped_value;
  logic [StatW-1:0]        status;
  logic                    all_empty;

  modport source (output valid, popped_value, status, all_empty, input ready);
  modport sink   (input valid, popped_value, status, all_empty, output ready);
endinterface

// Capacity register write channel
interface bstk_cfg_if import bstk_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] plates_per_stack;

  modport source (output valid, plates_per_stack, input ready);
  modport sink   (input valid, plates_per_stack, output ready);
endinterface

// ===== hw/rtl/banked_stack_with_pop_at.sv =====
// Banked stack with pop-at: STACKS sub-stacks of up to plates_per_stack signed words each act
// as one stack. Push fills the current sub-stack and moves to the next when it is full; pop
// removes the top word of the nearest non-empty sub-stack at or below the current one; pop-at
// does the same starting from the named sub-stack and leaves the current one alone. Each
// request yields one result with the popped word, a status (ok, overflow, underflow) and an
// all-empty flag. Requests are handled one at a time: a push passes the fill state, a pop the
// fill and plate states, and a dropped push, an underflow or an unused code goes straight to
// the done state; the steps follow the read of the per-sub-stack fill count and then the read
// or write of the plate memory, both synchronous single-port memories. The request channel is
// ready again in the cycle after the result register is loaded, and a result waiting at the
// output does not hold back the next request. Plate words are not cleared at reset; none is
// read before written. The capacity register may be written at any time the block is idle.
module banked_stack_with_pop_at import bstk_pkg::*; #(
  parameter int unsigned MAX_PLATES = MaxPlatesDef,
  parameter int unsigned STACKS     = StacksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bstk_cfg_if.sink   cfg_i,
  bstk_in_if.sink    in_i,
  bstk_out_if.source out_o
);

  localparam int unsigned Depth = STACKS * MAX_PLATES;
  localparam int unsigned SW    = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int unsigned FW    = $clog2(MAX_PLATES + 1);
  localparam int unsigned TW    = $clog2(Depth + 1);
  localparam int unsigned PW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [SW-1:0] LastStack = SW'(STACKS - 1);

  // Control state
  bstk_state_e       state_q, state_d;
  logic [STACKS-1:0] nonempty_q, nonempty_d;
  logic [SW-1:0]     cur_q, cur_d;
  logic [FW-1:0]     cur_fill_q, cur_fill_d;
  logic [TW-1:0]     total_q, total_d;
  logic [CapW-1:0]   cap_q;
  logic              out_valid_q, out_valid_d;

  // Per-request registers
  bstk_op_e          op_q, op_d;
  logic [WordW-1:0]  val_q, val_d;
  logic [SW-1:0]     sub_q, sub_d;
  bstk_status_e      status_q, status_d;
  logic              pop_ok_q, pop_ok_d;

  // Result register
  logic signed [WordW-1:0] out_value_q, out_value_d;
  bstk_status_e            out_status_q, out_status_d;
  logic                    out_empty_q, out_empty_d;

  // Memories
  logic [FW-1:0]    fill_mem [STACKS];
  logic [WordW-1:0] plate_mem [Depth];
  logic [FW-1:0]    fill_rd_q;
  logic [WordW-1:0] plate_rd_q;
  logic             fill_re, fill_we, plate_re, plate_we;
  logic [SW-1:0]    fill_raddr;
  logic [FW-1:0]    fill_wdata;
  logic [PW-1:0]    plate_addr;

  // Helpers
  bstk_op_e      op_in;
  logic          accept, out_free;
  logic [FW-1:0] eff_cap, fd, off;
  logic          cur_full, push_ovf;
  logic [SW-1:0] start_at, start, found_idx;
  logic          found;

  // Register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      cap_q <= cfg_i.plates_per_stack;
    end
  end

  // Clamp capacity into 1..MAX_PLATES
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = FW'(1);
    end else if (32'(cap_q) > MAX_PLATES) begin
      eff_cap = FW'(MAX_PLATES);
    end else begin
      eff_cap = FW'(cap_q);
    end
  end

  // Handshake
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign op_in      = bstk_op_e'(in_i.operation);
  assign out_free   = !out_valid_q || out_o.ready;

  // Search start and nearest non-empty sub-stack at or below it
  assign start_at = (32'(in_i.stack_index) >= STACKS) ? LastStack : SW'(32'(in_i.stack_index));
  assign start    = (op_in == OP_POP_AT) ? start_at : cur_q;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < STACKS; i++) begin
      if (nonempty_q[i] && (i <= int'(start))) begin
        found     = 1'b1;
        found_idx = SW'(i);
      end
    end
  end

  assign cur_full = (cur_fill_q >= eff_cap);
  assign push_ovf = cur_full && (cur_q == LastStack);

  // Fill count of the selected sub-stack; an empty one may hold a stale or unwritten entry
  assign fd  = nonempty_q[sub_q] ? fill_rd_q : '0;
  assign off = (op_q == OP_PUSH) ? fd : fd - FW'(1);
  assign plate_addr = PW'(32'(sub_q) * MAX_PLATES + 32'(off));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_PUSH:          state_d = push_ovf ? S_DONE : S_FILL;
            OP_POP, OP_POP_AT: state_d = found ? S_FILL : S_DONE;
            default:          state_d = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        state_d = (op_q == OP_PUSH) ? S_DONE : S_PLATE;
      end
      S_PLATE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    nonempty_d   = nonempty_q;
    cur_d        = cur_q;
    cur_fill_d   = cur_fill_q;
    total_d      = total_q;
    op_d         = op_q;
    val_d        = val_q;
    sub_d        = sub_q;
    status_d     = status_q;
    pop_ok_d     = pop_ok_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_empty_d  = out_empty_q;
    fill_re      = 1'b0;
    fill_raddr   = sub_d;
    fill_we      = 1'b0;
    fill_wdata   = fd;
    plate_re     = 1'b0;
    plate_we     = 1'b0;

    case (state_q)
      // Take the request and pick the sub-stack
      S_IDLE: begin
        if (accept) begin
          op_d     = op_in;
          val_d    = in_i.push_value;
          status_d = STAT_OK;
          pop_ok_d = 1'b0;
          case (op_in)
            OP_PUSH: begin
              if (push_ovf) begin
                status_d = STAT_OVERFLOW;
              end else begin
                sub_d   = cur_full ? cur_q + SW'(1) : cur_q;
                fill_re = 1'b1;
              end
            end
            OP_POP, OP_POP_AT: begin
              if (found) begin
                sub_d   = found_idx;
                fill_re = 1'b1;
              end else begin
                status_d = STAT_UNDERFLOW;
                if (op_in == OP_POP) begin
                  cur_d      = '0;
                  cur_fill_d = '0;
                end
              end
            end
            default: ;
          endcase
          fill_raddr = sub_d;
        end
      end
      // Read-modify-write the fill count, access the plate
      S_FILL: begin
        case (op_q)
          OP_PUSH: begin
            if (fd >= eff_cap) begin
              status_d = STAT_OVERFLOW;
            end else begin
              plate_we          = 1'b1;
              fill_we           = 1'b1;
              fill_wdata        = fd + FW'(1);
              nonempty_d[sub_q] = 1'b1;
              total_d           = total_q + TW'(1);
              cur_d             = sub_q;
              cur_fill_d        = fd + FW'(1);
            end
          end
          OP_POP, OP_POP_AT: begin
            plate_re          = 1'b1;
            pop_ok_d          = 1'b1;
            fill_we           = 1'b1;
            fill_wdata        = fd - FW'(1);
            nonempty_d[sub_q] = (fd != FW'(1));
            total_d           = total_q - TW'(1);
            if (op_q == OP_POP) begin
              cur_d      = sub_q;
              cur_fill_d = fd - FW'(1);
            end else if (sub_q == cur_q) begin
              cur_fill_d = fd - FW'(1);
            end
          end
          default: ;
        endcase
      end
      S_PLATE: ;
      // Load the result register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = pop_ok_q ? plate_rd_q : '0;
          out_status_d = status_q;
          out_empty_d  = (total_q == '0);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nonempty_q  <= '0;
      cur_q       <= '0;
      cur_fill_q  <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nonempty_q  <= nonempty_d;
      cur_q       <= cur_d;
      cur_fill_q  <= cur_fill_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    sub_q        <= sub_d;
    status_q     <= status_d;
    pop_ok_q     <= pop_ok_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_empty_q  <= out_empty_d;
  end

  // Fill count memory
  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[sub_q] <= fill_wdata;
    end
    if (fill_re) begin
      fill_rd_q <= fill_mem[fill_raddr];
    end
  end

  // Plate memory
  always_ff @(posedge clk_i) begin
    if (plate_we) begin
      plate_mem[plate_addr] <= val_q;
    end
    if (plate_re) begin
      plate_rd_q <= plate_mem[plate_addr];
    end
  end

  // Outputs
  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = out_value_q;
  assign out_o.status       = out_status_q;
  assign out_o.all_empty    = out_empty_q;

`ifndef NO_ASSERTIONS
  a_total_matches_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q == '0) == (nonempty_q == '0))
    else $error("total count disagrees with occupancy");

  a_above_current_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((nonempty_q >> cur_q) >> 1) == '0)
    else $error("sub-stack above current one holds plates");

  a_cur_fill_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !nonempty_q[cur_q] |-> (cur_fill_q == '0))
    else $error("current fill count stale for empty sub-stack");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside completion state");
`endif

endmodule

// ===== bench/bstk_checker.sv =====
`timescale 1ns / 100ps

module bstk_checker import bstk_pkg::*; #(
  parameter int unsigned MAX_PLATES = MaxPlatesDef,
  parameter int unsigned STACKS     = StacksDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  bstk_cfg_if  cfg_i,
  bstk_in_if   req_i,
  bstk_out_if  rsp_i,
  output int   fail_count_o,
  output int   results_seen_o
);

  typedef struct packed {
    logic signed [WordW-1:0] popped;
    bstk_status_e            status;
    logic                    empty;
  } stack_answer_t;

  // Shadow copy of the banked stack
  logic [WordW-1:0] plate_mem [STACKS][MAX_PLATES];
  int unsigned      plate_fill [STACKS];
  int unsigned      top_bank;
  int unsigned      plates_held;
  logic [CapW-1:0]  capacity_reg;

  stack_answer_t answers_due [$];

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // Walk down from a bank to the first one holding plates; STACKS if none
  function automatic int unsigned nearest_loaded(input int unsigned start);
    for (int i = int'(start); i >= 0; i--) begin
      if (plate_fill[i] != 0) return i;
    end
    return STACKS;
  endfunction

  // Remove the top plate of a non-empty bank
  function automatic logic [WordW-1:0] take_top(input int unsigned bank);
    plate_fill[bank]--;
    plates_held--;
    return plate_mem[bank][plate_fill[bank]];
  endfunction

  // Apply one request to the shadow stack and queue the answer it must give
  task automatic stack_apply(input logic [OpW-1:0] op, input logic [WordW-1:0] word,
                             input logic [IdxW-1:0] idx);
    stack_answer_t ans;
    int unsigned   cap;
    int unsigned   bank;
    ans.popped = '0;
    ans.status = STAT_OK;
    ans.empty  = 1'b0;
    // Clamp capacity into 1..MAX_PLATES
    if (capacity_reg == 0) cap = 1;
    else if (capacity_reg > MAX_PLATES) cap = MAX_PLATES;
    else cap = capacity_reg;
    case (op)
      OP_PUSH: begin
        bank = top_bank;
        if (plate_fill[bank] >= cap) begin
          if (bank + 1 >= STACKS) ans.status = STAT_OVERFLOW;
          else bank++;
        end
        if (ans.status == STAT_OK && plate_fill[bank] < cap) begin
          top_bank = bank;
          plate_mem[bank][plate_fill[bank]] = word;
          plate_fill[bank]++;
          plates_held++;
        end else begin
          ans.status = STAT_OVERFLOW;
        end
      end
      OP_POP: begin
        bank = nearest_loaded(top_bank);
        if (bank >= STACKS) begin
          top_bank   = 0;
          ans.status = STAT_UNDERFLOW;
        end else begin
          top_bank   = bank;
          ans.popped = take_top(bank);
        end
      end
      OP_POP_AT: begin
        bank = (idx >= STACKS) ? STACKS - 1 : idx;
        bank = nearest_loaded(bank);
        if (bank >= STACKS) ans.status = STAT_UNDERFLOW;
        else ans.popped = take_top(bank);
      end
      default: begin
        // unused code leaves everything alone
      end
    endcase
    ans.empty = (plates_held == 0);
    answers_due.push_back(ans);
  endtask

  // Compare one result transfer with the oldest queued answer
  task automatic check_answer();
    stack_answer_t want;
    if (answers_due.size() == 0) begin
      flag_mismatch($sformatf("result with no request pending: value %0d status %0d empty %0b",
                              rsp_i.popped_value, rsp_i.status, rsp_i.all_empty));
    end else begin
      want = answers_due.pop_front();
      if (rsp_i.popped_value !== want.popped)
        flag_mismatch($sformatf("popped_value got %0d expected %0d",
                                rsp_i.popped_value, want.popped));
      if (rsp_i.status !== want.status)
        flag_mismatch($sformatf("status got %0d expected %0d", rsp_i.status, want.status));
      if (rsp_i.all_empty !== want.empty)
        flag_mismatch($sformatf("all_empty got %0b expected %0b",
                                rsp_i.all_empty, want.empty));
      results_seen_o <= results_seen_o + 1;
    end
  endtask

  // Track register writes, requests and results at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (plate_fill[i]) plate_fill[i] = 0;
      top_bank       = 0;
      plates_held    = 0;
      capacity_reg   = CapReset;
      fail_count_o   = 0;
      results_seen_o <= 0;
      answers_due.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) capacity_reg = cfg_i.plates_per_stack;
      if (req_i.valid && req_i.ready)
        stack_apply(req_i.operation, req_i.push_value, req_i.stack_index);
      if (rsp_i.valid && rsp_i.ready) check_answer();
    end
  end

endmodule

// ===== bench/banked_stack_with_pop_at_test.sv =====
`timescale 1ns / 100ps

module banked_stack_with_pop_at_test;
  import bstk_pkg::*;

  // Unused operation code: the block must answer ok with a zero word
  localparam logic [OpW-1:0] OP_NONE = 2'd3;
  localparam int unsigned HoldCycles    = 600;
  localparam int unsigned ItemsPerPhase = 127;
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned DrainCycles   = 20;

  logic clk_i;
  logic rst_ni;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  bit   long_hold = 1'b0;
  int   items_sent = 0;
  int   fail_count;
  int   results_seen;

  logic [CapW-1:0] cap_plan [PhaseCount] = '{8'd1, 8'd2, 8'd255, 8'd3, 8'd5, 8'd0,
                                             8'd128, 8'd4, 8'd129, 8'd1, 8'd7, 8'd2};

  bstk_cfg_if cfg_if ();
  bstk_in_if  req_if ();
  bstk_out_if rsp_if ();

  banked_stack_with_pop_at #(
    .MAX_PLATES(MaxPlatesDef),
    .STACKS    (StacksDef)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  bstk_checker #(
    .MAX_PLATES(MaxPlatesDef),
    .STACKS    (StacksDef)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_if),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .fail_count_o  (fail_count),
    .results_seen_o(results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, or one long hold-off when requested
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold = 1'b0;
      end
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #(2_000_000);
    $display("banked_stack_with_pop_at verification failed");
    $finish;
  end

  // Write the capacity register; call only while the block is idle
  task automatic write_cap(input logic [CapW-1:0] plates);
    cfg_if.valid            <= 1'b1;
    cfg_if.plates_per_stack <= plates;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Offer one request after a random gap and hold it until the transfer
  task automatic send_req(input logic [OpW-1:0] op, input logic [WordW-1:0] word,
                          input logic [IdxW-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.push_value  <= word;
    req_if.stack_index <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  // Random request: mostly pushes and pops, a little unused-code noise
  task automatic send_random(input int unsigned push_pct);
    int unsigned      roll;
    logic [OpW-1:0]   op;
    logic [WordW-1:0] word;
    roll = $urandom_range(99);
    if (roll < 3) op = OP_NONE;
    else if (roll < 3 + push_pct) op = OP_PUSH;
    else if (roll[0]) op = OP_POP;
    else op = OP_POP_AT;
    case ($urandom_range(15))
      0:       word = 32'h7FFF_FFFF;
      1:       word = 32'h8000_0000;
      2:       word = '0;
      3:       word = '1;
      default: word = $urandom();
    endcase
    send_req(op, word, IdxW'($urandom_range(15)));
  endtask

  // Drop valid and hold until every answer has come back
  task automatic finish_phase();
    req_if.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_if.valid            <= 1'b0;
    cfg_if.plates_per_stack <= '0;
    req_if.valid            <= 1'b0;
    req_if.operation        <= OP_PUSH;
    req_if.push_value       <= '0;
    req_if.stack_index      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero capacity acts as one plate per bank; pops on empty, holes, walk-down
    write_cap(8'd0);
    send_req(OP_POP, '0, 4'd0);
    send_req(OP_POP_AT, '0, 4'd15);
    send_req(OP_NONE, 32'h1234_5678, 4'd9);
    send_req(OP_PUSH, 32'h7FFF_FFFF, 4'd0);
    send_req(OP_PUSH, 32'h8000_0000, 4'd15);
    send_req(OP_PUSH, '0, 4'd0);
    send_req(OP_POP_AT, '0, 4'd0);
    send_req(OP_POP_AT, '0, 4'd15);
    send_req(OP_POP, '0, 4'd0);
    send_req(OP_POP, '0, 4'd0);
    finish_phase();

    // Fill bank zero with three plates, then lower capacity below its fill
    write_cap(8'd3);
    send_req(OP_PUSH, '1, 4'd0);
    send_req(OP_PUSH, 32'd1, 4'd0);
    send_req(OP_PUSH, 32'd5, 4'd0);
    finish_phase();
    write_cap(8'd1);
    send_req(OP_PUSH, 32'd9, 4'd0);
    send_req(OP_POP, '0, 4'd0);
    send_req(OP_POP, '0, 4'd0);

    // Fill every bank, then one more push overflows
    for (int i = 0; i < StacksDef; i++) send_req(OP_PUSH, $urandom(), 4'd0);
    finish_phase();

    // Random phases over capacities and idle patterns
    for (int p = 0; p < PhaseCount; p++) begin
      write_cap(cap_plan[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      if (p == 4) long_hold = 1'b1;
      repeat (ItemsPerPhase) send_random((p % 2 == 0) ? 65 : 35);
      finish_phase();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("banked_stack_with_pop_at verification clean");
    end else begin
      $display("banked_stack_with_pop_at verification failed");
    end
    $finish;
  end

endmodule
